>>> rtl/rxdfd_pkg.sv
// Package for the XOR-delta run-length frame decoder.
// Holds state and command codes, field widths and token header decode helpers.
// No dependencies.
`default_nettype none

package rxdfd_pkg;

    localparam int unsigned FRAME_BYTES_DEF = 262144;

    localparam int unsigned BPP_W   = 3;
    localparam int unsigned FSIZE_W = 19;
    localparam int unsigned CFG_W   = 19;
    localparam int unsigned PTR_W   = 19;
    localparam int unsigned RADDR_W = 18;
    localparam int unsigned RUN_W   = 20;
    localparam int unsigned TOTAL_W = 23;
    localparam int unsigned PIX_W   = 32;
    localparam int unsigned PHASE_W = 3;

    localparam logic [BPP_W-1:0]   BPP_RST   = 3'd1;
    localparam logic [FSIZE_W-1:0] FSIZE_RST = 19'h40000;

    // configuration register indexes
    localparam logic CFG_BPP   = 1'b0;
    localparam logic CFG_FSIZE = 1'b1;

    typedef enum logic [1:0] {
        CMD_FEED  = 2'd0,
        CMD_START = 2'd1,
        CMD_READ  = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CALC,
        ST_EMIT,
        ST_CLEAR,
        ST_RESP
    } t_state;

    // header 11xxxxxx marks a run token
    function automatic logic is_run(input logic [7:0] hdr);
        return hdr[7:6] == 2'b11;
    endfunction

    // count bytes that follow a run header
    function automatic logic [1:0] count_bytes(input logic [7:0] hdr);
        if (!hdr[5]) begin
            return 2'd0;
        end
        return hdr[4] ? 2'd2 : 2'd1;
    endfunction

    // 0 acts as 1, 5..7 act as 4
    function automatic logic [2:0] pixel_width(input logic [BPP_W-1:0] bpp);
        if (bpp == 3'd0) begin
            return 3'd1;
        end
        if (bpp > 3'd4) begin
            return 3'd4;
        end
        return bpp;
    endfunction

endpackage

`default_nettype wire

>>> rtl/rle_xor_delta_frame_decoder.sv
// XOR-delta run-length frame decoder, top level.
// Single module: token decoder, frame store memory with read-modify-write engine.
// Depends on rxdfd_pkg.
//
// Channel  | Dir | tdata (low bit up)                               | tuser
// s_axis   | in  | data_byte[7:0], read_address[25:8], zero pad    | command[1:0]
// m_axis   | out | read_data[7:0], bytes_written[26:8],            | -
//          |     | overflow[27], token_pending[28], zero pad       |
// cfg      | in  | i_cfg_we, i_cfg_index (0 bytes_per_pixel, 1 frame_size), i_cfg_data
//
// One transaction at a time. A completed token runs a read-modify-write walk: each
// store byte is read while the previous one is written back; a token that writes
// nothing skips the walk. Clear store: one store entry zeroed per cycle.
// After reset a clearing pass runs with s_axis tready low.
// A result waiting on m_axis holds the finished item in its response state.
`default_nettype none

module rle_xor_delta_frame_decoder
    import rxdfd_pkg::*;
#(
    parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  wire logic [31:0]       i_s_axis_tdata,   // data_byte, read_address
    input  wire logic [1:0]        i_s_axis_tuser,   // command
    output logic                   o_m_axis_tvalid,
    input  wire logic              i_m_axis_tready,
    output logic [31:0]            o_m_axis_tdata,   // read_data, bytes_written,
                                                     // overflow, token_pending
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_index,
    input  wire logic [CFG_W-1:0]  i_cfg_data
);

    localparam int unsigned AW = $clog2(FRAME_BYTES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(FRAME_BYTES - 1);

    // frame store
    logic [7:0]    mem_store [FRAME_BYTES];
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    r_rdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_store[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem_store[mem_raddr];
        end
    end

    // configuration
    logic [BPP_W-1:0]   r_bpp;
    logic [FSIZE_W-1:0] r_fsize;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp   <= BPP_RST;
            r_fsize <= FSIZE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BPP:   r_bpp   <= i_cfg_data[BPP_W-1:0];
                CFG_FSIZE: r_fsize <= i_cfg_data[FSIZE_W-1:0];
                default:   r_bpp   <= r_bpp;
            endcase
        end
    end

    // state
    t_state             r_state, n_state;
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [7:0]         r_hdr, n_hdr;
    logic [RUN_W-1:0]   r_rl, n_rl;
    logic [PIX_W-1:0]   r_pix, n_pix;
    logic [PTR_W-1:0]   r_ptr, n_ptr;
    logic               r_ovf, n_ovf;
    logic [TOTAL_W-1:0] r_total, n_total;
    logic [PTR_W-1:0]   r_cnt, n_cnt;
    logic [1:0]         r_k, n_k;
    logic               r_wr_pend, n_wr_pend;
    logic [AW-1:0]      r_wr_addr, n_wr_addr;
    logic [7:0]         r_wr_byte, n_wr_byte;
    logic [AW-1:0]      r_clr_addr, n_clr_addr;
    logic               r_rd_hit, n_rd_hit;

    logic               r_out_valid, n_out_valid;
    logic [7:0]         r_out_rd, n_out_rd;
    logic [PTR_W-1:0]   r_out_bw, n_out_bw;
    logic               r_out_ovf, n_out_ovf;
    logic               r_out_pend, n_out_pend;

    // input fields
    t_cmd               in_cmd;
    logic [7:0]         in_byte;
    logic [RADDR_W-1:0] in_raddr;
    logic               in_acc;

    assign in_cmd   = t_cmd'(i_s_axis_tuser);
    assign in_byte  = i_s_axis_tdata[7:0];
    assign in_raddr = i_s_axis_tdata[25:8];
    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;

    // token decode helpers
    logic [2:0]         width;
    logic [7:0]         hdr_nx;
    logic               run_nx;
    logic [1:0]         nc_nx;
    logic [PHASE_W-1:0] idx;
    logic               idx_ok;
    logic [PHASE_W-1:0] phase_inc;
    logic [3:0]         need;
    logic               tok_done;
    logic [RUN_W-1:0]   rl_nx;
    logic [PIX_W-1:0]   pix_nx;
    logic [TOTAL_W-1:0] run_total;
    logic [PTR_W-1:0]   limit;
    logic [PTR_W-1:0]   room;
    logic               rd_in_range;
    logic [2:0]         k_inc;

    assign width       = pixel_width(r_bpp);
    assign hdr_nx      = (r_phase == '0) ? in_byte : r_hdr;
    assign run_nx      = is_run(hdr_nx);
    assign nc_nx       = count_bytes(hdr_nx);
    assign phase_inc   = r_phase + 3'd1;
    assign need        = run_nx ? (4'd1 + {2'b0, nc_nx} + {1'b0, width}) : {1'b0, width};
    assign tok_done    = ({1'b0, phase_inc} >= need) || (phase_inc == '0);
    assign limit       = (32'(r_fsize) < FRAME_BYTES) ? r_fsize : PTR_W'(FRAME_BYTES);
    assign room        = (r_ptr < limit) ? (limit - r_ptr) : '0;
    assign rd_in_range = 32'(in_raddr) < FRAME_BYTES;
    assign k_inc       = {1'b0, r_k} + 3'd1;

    // byte slot of the pixel for a non-header byte
    always_comb begin
        idx    = '0;
        idx_ok = 1'b0;
        if (r_phase != '0) begin
            if (run_nx) begin
                idx_ok = r_phase > {1'b0, nc_nx};
                idx    = r_phase - 3'd1 - {1'b0, nc_nx};
            end else begin
                idx_ok = 1'b1;
                idx    = r_phase;
            end
        end
    end

    always_comb begin
        rl_nx  = r_rl;
        pix_nx = r_pix;
        if (r_phase == '0) begin
            if (run_nx) begin
                rl_nx  = in_byte[5] ? {16'd0, in_byte[3:0]} : {15'd0, in_byte[4:0]};
                pix_nx = '0;
            end else begin
                rl_nx  = '0;
                pix_nx = {24'd0, in_byte};
            end
        end else if (run_nx && !idx_ok) begin
            rl_nx = {r_rl[RUN_W-9:0], in_byte};
        end else begin
            for (int i = 0; i < 4; i++) begin
                if (idx == PHASE_W'(i)) begin
                    pix_nx[8*i +: 8] = r_pix[8*i +: 8] | in_byte;
                end
            end
        end
    end

    // run count times pixel width, width is 1..4
    always_comb begin
        case (width)
            3'd2:    run_total = {2'b0, rl_nx, 1'b0};
            3'd3:    run_total = {3'b0, rl_nx} + {2'b0, rl_nx, 1'b0};
            3'd4:    run_total = {1'b0, rl_nx, 2'b0};
            default: run_total = {3'b0, rl_nx};
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_hdr       = r_hdr;
        n_rl        = r_rl;
        n_pix       = r_pix;
        n_ptr       = r_ptr;
        n_ovf       = r_ovf;
        n_total     = r_total;
        n_cnt       = r_cnt;
        n_k         = r_k;
        n_wr_pend   = 1'b0;
        n_wr_addr   = r_wr_addr;
        n_wr_byte   = r_wr_byte;
        n_clr_addr  = r_clr_addr;
        n_rd_hit    = r_rd_hit;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_rd    = r_out_rd;
        n_out_bw    = r_out_bw;
        n_out_ovf   = r_out_ovf;
        n_out_pend  = r_out_pend;
        mem_we      = 1'b0;
        mem_waddr   = r_wr_addr;
        mem_wdata   = r_rdata ^ r_wr_byte;
        mem_re      = 1'b0;
        mem_raddr   = AW'(32'(r_ptr));
        o_s_axis_tready = 1'b0;

        case (r_state)
            ST_INIT, ST_CLEAR: begin
                mem_we     = 1'b1;
                mem_waddr  = r_clr_addr;
                mem_wdata  = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == LAST_ADDR) begin
                    n_clr_addr = '0;
                    n_state    = (r_state == ST_INIT) ? ST_IDLE : ST_RESP;
                end
            end
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (in_acc) begin
                    n_rd_hit = 1'b0;
                    n_state  = ST_RESP;
                    case (in_cmd)
                        CMD_FEED: begin
                            n_hdr   = hdr_nx;
                            n_rl    = rl_nx;
                            n_pix   = pix_nx;
                            n_phase = phase_inc;
                            if (tok_done) begin
                                n_phase = '0;
                                n_total = run_nx ? run_total : TOTAL_W'(width);
                                n_state = ST_CALC;
                            end
                        end
                        CMD_START: begin
                            n_ptr   = '0;
                            n_ovf   = 1'b0;
                            n_phase = '0;
                            n_hdr   = '0;
                            n_rl    = '0;
                            n_pix   = '0;
                        end
                        CMD_READ: begin
                            mem_re    = rd_in_range;
                            mem_raddr = AW'(32'(in_raddr));
                            n_rd_hit  = rd_in_range;
                        end
                        CMD_CLEAR: begin
                            n_state = ST_CLEAR;
                        end
                        default: n_state = ST_RESP;
                    endcase
                end
            end
            ST_CALC: begin
                n_k = '0;
                if (r_total > TOTAL_W'(room)) begin
                    n_cnt = room;
                    n_ovf = 1'b1;
                end else begin
                    n_cnt = r_total[PTR_W-1:0];
                end
                n_state = ((r_total == '0) || (room == '0)) ? ST_RESP : ST_EMIT;
            end
            ST_EMIT: begin
                // read at the pointer while the previous byte is written back
                mem_we = r_wr_pend;
                if (r_cnt != '0) begin
                    mem_re    = 1'b1;
                    n_wr_pend = 1'b1;
                    n_wr_addr = AW'(32'(r_ptr));
                    n_wr_byte = r_pix[8*r_k +: 8];
                    n_ptr     = r_ptr + 1'b1;
                    n_cnt     = r_cnt - 1'b1;
                    n_k       = (k_inc >= width) ? 2'd0 : k_inc[1:0];
                end else begin
                    n_state = ST_RESP;
                end
            end
            ST_RESP: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_rd    = r_rd_hit ? r_rdata : 8'd0;
                    n_out_bw    = r_ptr;
                    n_out_ovf   = r_ovf;
                    n_out_pend  = r_phase != '0;
                    n_rd_hit    = 1'b0;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_phase     <= '0;
            r_hdr       <= '0;
            r_rl        <= '0;
            r_pix       <= '0;
            r_ptr       <= '0;
            r_ovf       <= 1'b0;
            r_cnt       <= '0;
            r_k         <= '0;
            r_wr_pend   <= 1'b0;
            r_clr_addr  <= '0;
            r_rd_hit    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_hdr       <= n_hdr;
            r_rl        <= n_rl;
            r_pix       <= n_pix;
            r_ptr       <= n_ptr;
            r_ovf       <= n_ovf;
            r_cnt       <= n_cnt;
            r_k         <= n_k;
            r_wr_pend   <= n_wr_pend;
            r_clr_addr  <= n_clr_addr;
            r_rd_hit    <= n_rd_hit;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_total    <= n_total;
        r_wr_addr  <= n_wr_addr;
        r_wr_byte  <= n_wr_byte;
        r_out_rd   <= n_out_rd;
        r_out_bw   <= n_out_bw;
        r_out_ovf  <= n_out_ovf;
        r_out_pend <= n_out_pend;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b0, r_out_pend, r_out_ovf, r_out_bw, r_out_rd};

    // a write-back never lands on the entry being read in the same cycle
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("store write and read hit the same entry");

    // an accepted transaction always leaves idle
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != ST_IDLE))
        else $error("accepted transaction did not start work");

    // results are only loaded from the response state
    a_out_from_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(r_state == ST_RESP))
        else $error("result appeared outside the response state");

    // store is only written by the RMW walk or a clearing pass
    a_write_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == ST_EMIT || r_state == ST_INIT || r_state == ST_CLEAR))
        else $error("unexpected store write");

endmodule

`default_nettype wire
